// ----- rtl/core/voltage_step_regulator_core_defines.svh -----
// assertion macros for the voltage step regulator core
`ifndef VOLTAGE_STEP_REGULATOR_CORE_DEFINES_SVH
`define VOLTAGE_STEP_REGULATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VSR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vsr check failed");

// next-cycle implication, disabled during reset
`define VSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vsr check failed");

`endif

// ----- rtl/core/vsr_pkg.sv -----
// shared types and constants for the voltage step regulator
`default_nettype none

package vsr_pkg;

   localparam int unsigned VOLT_W = 16;
   localparam int unsigned OP_W = 3;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [VOLT_W-1:0] VOLT_SAT = '1;

   localparam logic [VOLT_W-1:0] VOLTAGE_MAX_RESET      = 16'd65535;
   localparam logic [VOLT_W-1:0] VOLTAGE_MIN_RESET      = 16'd0;
   localparam logic [VOLT_W-1:0] REGULATE_TIMEOUT_RESET = 16'd60000;
   localparam logic [VOLT_W-1:0] READING_TIMEOUT_RESET  = 16'd10000;
   localparam logic [VOLT_W-1:0] STEP_WAIT_RESET        = 16'd1200;

   typedef enum logic [OP_W-1:0] {
      OP_SET_POINT    = 3'd0,
      OP_STEP_UP      = 3'd1,
      OP_STEP_DOWN    = 3'd2,
      OP_ABORT        = 3'd3,
      OP_READING      = 3'd4,
      OP_TICK         = 3'd5,
      OP_DEVICE_ERROR = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      MODE_IDLE       = 3'd0,
      MODE_FIND       = 3'd1,
      MODE_CHECK_UP   = 3'd2,
      MODE_STEP_UP    = 3'd3,
      MODE_CHECK_DOWN = 3'd4,
      MODE_STEP_DOWN  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_OVERALL = 2'd1,
      CAUSE_READING = 2'd2,
      CAUSE_DEVICE  = 2'd3
   } cause_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VOLTAGE_MAX      = 3'd0,
      CSR_VOLTAGE_MIN      = 3'd1,
      CSR_REGULATE_TIMEOUT = 3'd2,
      CSR_READING_TIMEOUT  = 3'd3,
      CSR_STEP_WAIT        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [VOLT_W-1:0] voltage_max;
      logic [VOLT_W-1:0] voltage_min;
      logic [VOLT_W-1:0] regulate_timeout;
      logic [VOLT_W-1:0] reading_timeout;
      logic [VOLT_W-1:0] step_wait;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [VOLT_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic              ping_request;
      logic              level_up;
      logic              level_down;
      logic              voltage_set_done;
      logic              error_flag;
      cause_type         error_cause;
      logic              step_refused;
      logic [VOLT_W-1:0] setpoint;
      mode_type          mode;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/core/vsr_csr.sv -----
// configuration register file
`default_nettype none

module vsr_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [vsr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [vsr_pkg::VOLT_W-1:0]         csr_data,
   output vsr_pkg::cfg_type                        cfg
);
   import vsr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_VOLTAGE_MAX:      cfg_in.voltage_max = csr_data;
            CSR_VOLTAGE_MIN:      cfg_in.voltage_min = csr_data;
            CSR_REGULATE_TIMEOUT: cfg_in.regulate_timeout = csr_data;
            CSR_READING_TIMEOUT:  cfg_in.reading_timeout = csr_data;
            CSR_STEP_WAIT:        cfg_in.step_wait = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.voltage_max      <= VOLTAGE_MAX_RESET;
         cfg_ff.voltage_min      <= VOLTAGE_MIN_RESET;
         cfg_ff.regulate_timeout <= REGULATE_TIMEOUT_RESET;
         cfg_ff.reading_timeout  <= READING_TIMEOUT_RESET;
         cfg_ff.step_wait        <= STEP_WAIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/vsr_engine.sv -----
// regulator state and per-event update logic
`default_nettype none

module vsr_engine (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire vsr_pkg::item_type item,
   input  wire vsr_pkg::cfg_type  cfg,
   output vsr_pkg::result_type result
);
   import vsr_pkg::*;

   mode_type          mode_ff, mode_in;
   logic [VOLT_W-1:0] setpoint_ff, setpoint_in;
   logic [VOLT_W-1:0] reading_ff, reading_in;
   logic [VOLT_W-1:0] overall_ff, overall_in;
   logic [VOLT_W-1:0] phase_ff, phase_in;

   logic [VOLT_W:0]   up_sum;
   logic [VOLT_W-1:0] up_clamp;
   logic [VOLT_W-1:0] up_point;
   logic [VOLT_W-1:0] down_diff;
   logic [VOLT_W-1:0] down_point;
   logic [VOLT_W-1:0] overall_inc;
   logic [VOLT_W-1:0] phase_inc;
   logic              above_set;
   logic              above_max;

   always_comb begin
      up_sum = {1'b0, reading_ff} + {1'b0, item.value};
      up_clamp = (up_sum > {1'b0, cfg.voltage_max}) ? cfg.voltage_max : up_sum[VOLT_W-1:0];
      up_point = (up_clamp < cfg.voltage_min) ? cfg.voltage_min : up_clamp;
      down_diff = reading_ff - item.value;
      down_point = (reading_ff >= item.value && down_diff > cfg.voltage_min)
         ? down_diff : cfg.voltage_min;
      overall_inc = (overall_ff == VOLT_SAT) ? overall_ff : overall_ff + 1'b1;
      phase_inc = (phase_ff == VOLT_SAT) ? phase_ff : phase_ff + 1'b1;
      above_set = item.value >= setpoint_ff;
      above_max = item.value >= cfg.voltage_max;
   end

   always_comb begin
      mode_in = mode_ff;
      setpoint_in = setpoint_ff;
      reading_in = reading_ff;
      overall_in = overall_ff;
      phase_in = phase_ff;
      result = '0;

      case (item.op) inside
         OP_SET_POINT, OP_STEP_DOWN: begin
            setpoint_in = (item.op == OP_SET_POINT) ? item.value : down_point;
            mode_in = MODE_FIND;
            overall_in = '0;
            phase_in = '0;
            result.ping_request = 1'b1;
         end
         OP_STEP_UP: begin
            if (reading_ff < cfg.voltage_max) begin
               setpoint_in = up_point;
               mode_in = MODE_FIND;
               overall_in = '0;
               phase_in = '0;
               result.ping_request = 1'b1;
            end else begin
               result.step_refused = 1'b1;
            end
         end
         OP_ABORT: begin
            mode_in = MODE_IDLE;
         end
         OP_READING: begin
            reading_in = item.value;
            unique case (mode_ff)
               MODE_FIND: begin
                  phase_in = '0;
                  if (above_set) begin
                     mode_in = MODE_STEP_DOWN;
                     result.level_down = 1'b1;
                  end else begin
                     mode_in = MODE_CHECK_UP;
                     result.ping_request = 1'b1;
                  end
               end
               MODE_CHECK_UP: begin
                  if (above_max || above_set) begin
                     mode_in = MODE_IDLE;
                     result.voltage_set_done = 1'b1;
                  end else begin
                     mode_in = MODE_STEP_UP;
                     phase_in = '0;
                     result.level_up = 1'b1;
                  end
               end
               MODE_CHECK_DOWN: begin
                  if (!above_set) begin
                     mode_in = MODE_IDLE;
                     result.voltage_set_done = 1'b1;
                  end else begin
                     mode_in = MODE_STEP_DOWN;
                     phase_in = '0;
                     result.level_down = 1'b1;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
         OP_TICK: begin
            if (mode_ff != MODE_IDLE) begin
               overall_in = overall_inc;
               phase_in = phase_inc;
               if (overall_inc >= cfg.regulate_timeout) begin
                  mode_in = MODE_IDLE;
                  result.error_flag = 1'b1;
                  result.error_cause = CAUSE_OVERALL;
               end else if (mode_ff == MODE_STEP_UP || mode_ff == MODE_STEP_DOWN) begin
                  if (phase_inc >= cfg.step_wait) begin
                     mode_in = (mode_ff == MODE_STEP_UP) ? MODE_CHECK_UP : MODE_CHECK_DOWN;
                     phase_in = '0;
                     result.ping_request = 1'b1;
                  end
               end else if (phase_inc >= cfg.reading_timeout) begin
                  mode_in = MODE_IDLE;
                  result.error_flag = 1'b1;
                  result.error_cause = CAUSE_READING;
               end
            end
         end
         OP_DEVICE_ERROR: begin
            if (mode_ff != MODE_IDLE) begin
               mode_in = MODE_IDLE;
               result.error_flag = 1'b1;
               result.error_cause = CAUSE_DEVICE;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase

      result.setpoint = setpoint_in;
      result.mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         setpoint_ff <= '0;
         reading_ff <= '0;
         overall_ff <= '0;
         phase_ff <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         setpoint_ff <= setpoint_in;
         reading_ff <= reading_in;
         overall_ff <= overall_in;
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/voltage_step_regulator_core.sv -----
// top level of the voltage step regulator
`default_nettype none

// Each event transfer on the req side yields exactly one result transfer on the rsp side:
// the event is first captured in the input register, then the update logic writes the
// regulator state and the result register together.
// One event is taken every cycle while the rsp side is ready; a result that waits on the
// rsp side holds the event behind it in the input register, so with both registers full
// every stalled rsp cycle also stalls the req side. Configuration writes are taken every cycle.
module voltage_step_regulator_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [15:0]                     req_tdata,  // value
   input  wire logic [vsr_pkg::OP_W-1:0]        req_tuser,  // op
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // ping_request, level_up, level_down, voltage_set_done, error_flag,
   // error_cause[1:0], step_refused, setpoint_out[15:0], mode_out[2:0], zero pad
   output logic [31:0]                          rsp_tdata,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [vsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [vsr_pkg::VOLT_W-1:0]      csr_data
);
   import vsr_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff, out_result_in;
   logic       out_free;
   logic       advance;

   vsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   vsr_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      out_free = !out_valid_ff || rsp_tready;
      advance = in_valid_ff && out_free;
      req_tready = !in_valid_ff || out_free;

      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      in_item_in = (req_tvalid && req_tready) ? item_type'{op: req_tuser, value: req_tdata}
                                              : in_item_ff;

      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_result_in = advance ? result : out_result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'b0,
                       out_result_ff.mode,
                       out_result_ff.setpoint,
                       out_result_ff.step_refused,
                       out_result_ff.error_cause,
                       out_result_ff.error_flag,
                       out_result_ff.voltage_set_done,
                       out_result_ff.level_down,
                       out_result_ff.level_up,
                       out_result_ff.ping_request};

endmodule

`default_nettype wire

// ----- rtl/core/vsr_checker.sv -----
// port-level checks for the voltage step regulator core
`default_nettype none

`include "voltage_step_regulator_core_defines.svh"

module vsr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);
   import vsr_pkg::*;

   logic     rsp_up;
   logic     rsp_down;
   logic     rsp_done;
   logic     rsp_error;
   logic     rsp_refused;
   logic     rsp_ping;
   logic [1:0] rsp_cause;
   logic [2:0] rsp_mode;

   assign rsp_ping = rsp_tdata[0];
   assign rsp_up = rsp_tdata[1];
   assign rsp_down = rsp_tdata[2];
   assign rsp_done = rsp_tdata[3];
   assign rsp_error = rsp_tdata[4];
   assign rsp_cause = rsp_tdata[6:5];
   assign rsp_refused = rsp_tdata[7];
   assign rsp_mode = rsp_tdata[26:24];

   // a stalled result keeps its content
   `VSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // ending regulation leaves the regulator idle, with a cause only on error
   `VSR_ASSERT_NOW(a_end_idle, clock, reset, rsp_tvalid && (rsp_done || rsp_error),
      rsp_mode == MODE_IDLE && (rsp_error == (rsp_cause != CAUSE_NONE)) && !rsp_ping)

   // a level pulse lands in the matching step mode
   `VSR_ASSERT_NOW(a_pulse_mode, clock, reset, rsp_tvalid && (rsp_up || rsp_down),
      (rsp_up ? rsp_mode == MODE_STEP_UP : rsp_mode == MODE_STEP_DOWN)
      && !(rsp_up && rsp_down) && !rsp_ping)

   // a refused step carries no other event flag
   `VSR_ASSERT_NOW(a_refused_alone, clock, reset, rsp_tvalid && rsp_refused,
      !rsp_ping && !rsp_up && !rsp_down && !rsp_done && !rsp_error)

endmodule

bind voltage_step_regulator_core vsr_checker u_vsr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
